// File: rtl/core/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types for the bubble sort engine: beat payloads, sequencer states,
// write-data selects and the control bundle from sequencer to datapath.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int VALUE_W = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_res;
    logic                      last_res;
    logic                      overflow;
  } out_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_PRIME,
    S_FIRST,
    S_SWEEP,
    S_FLUSH,
    S_EMIT,
    S_ECAP
  } state_e;

  typedef enum logic [1:0] {
    WR_INPUT,
    WR_LOW,
    WR_CARRY
  } wsel_e;

  typedef struct packed {
    logic  ram_we;
    wsel_e wsel;
    logic  carry_first;
    logic  carry_sweep;
    logic  out_ld;
    logic  out_last;
    logic  out_ovf;
  } ctrl_t;

endpackage

// File: rtl/core/bse_ram.sv
// ----------------------------------------------------------------------------
// bse_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read data output.
// ----------------------------------------------------------------------------
module bse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/bse_cmp.sv
// ----------------------------------------------------------------------------
// bse_cmp
// Shared compare-and-select unit: orders the carried value against the
// value just read, giving the smaller and the larger of the two.
// ----------------------------------------------------------------------------
module bse_cmp (
  input  logic signed [bse_pkg::VALUE_W-1:0] carry_i,
  input  logic signed [bse_pkg::VALUE_W-1:0] next_i,
  output logic signed [bse_pkg::VALUE_W-1:0] low_o,
  output logic signed [bse_pkg::VALUE_W-1:0] high_o
);
  import bse_pkg::*;

  logic swap;

  // Swap only on strictly greater; equal words are bit-identical anyway.
  assign swap   = carry_i > next_i;
  assign low_o  = swap ? next_i  : carry_i;
  assign high_o = swap ? carry_i : next_i;

endmodule

// File: rtl/core/bse_ctrl.sv
// ----------------------------------------------------------------------------
// bse_ctrl
// Sequencer of the bubble sort engine: load counting, sort passes over the
// store with a carried element, and emission of the sorted set.
// ----------------------------------------------------------------------------
module bse_ctrl #(
  parameter int  MAX_ITEMS = 64,
  localparam int AW        = $clog2(MAX_ITEMS),
  localparam int CW        = $clog2(MAX_ITEMS + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_stall_o,
  input  logic            out_free_i,
  output bse_pkg::ctrl_t  ctl_o,
  output logic [AW-1:0]   waddr_o,
  output logic [AW-1:0]   raddr_o
);
  import bse_pkg::*;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          dropped_q, dropped_d;
  logic [CW-1:0] pass_q, pass_d;
  logic [AW-1:0] k_q, k_d;
  logic [AW-1:0] idx_q, idx_d;

  logic          accept;
  logic          room;
  logic [CW-1:0] n_new;
  logic          more;
  logic          emit_last;

  assign accept    = in_valid_i && (state_q == S_LOAD);
  assign room      = count_q < CW'(MAX_ITEMS);
  assign n_new     = count_q + CW'(room);
  assign more      = (CW'(k_q) + CW'(2)) < pass_q;
  assign emit_last = (CW'(idx_q) + CW'(1)) == count_q;
  assign in_stall_o = (state_q != S_LOAD);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: begin
        if (accept && in_last_i) begin
          state_d = (n_new >= CW'(2)) ? S_PRIME : S_EMIT;
        end
      end
      S_PRIME: state_d = S_FIRST;
      S_FIRST: state_d = S_SWEEP;
      S_SWEEP: begin
        if (!more) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: state_d = (pass_q >= CW'(3)) ? S_PRIME : S_EMIT;
      S_EMIT: begin
        if (out_free_i) begin
          state_d = S_ECAP;
        end
      end
      S_ECAP:  state_d = emit_last ? S_LOAD : S_EMIT;
      default: state_d = S_LOAD;
    endcase
  end

  // Outputs to the datapath
  always_comb begin
    ctl_o   = '0;
    ctl_o.wsel = WR_INPUT;
    waddr_o = '0;
    raddr_o = '0;
    unique case (state_q)
      S_LOAD: begin
        ctl_o.ram_we = accept && room;
        waddr_o      = count_q[AW-1:0];
      end
      S_PRIME: raddr_o = '0;
      S_FIRST: begin
        ctl_o.carry_first = 1'b1;
        raddr_o           = AW'(1);
      end
      S_SWEEP: begin
        // Write the smaller one back, keep the larger one moving up.
        ctl_o.ram_we      = 1'b1;
        ctl_o.wsel        = WR_LOW;
        ctl_o.carry_sweep = 1'b1;
        waddr_o           = k_q;
        raddr_o           = AW'(CW'(k_q) + CW'(2));
      end
      S_FLUSH: begin
        ctl_o.ram_we = 1'b1;
        ctl_o.wsel   = WR_CARRY;
        waddr_o      = AW'(pass_q - CW'(1));
      end
      S_EMIT: raddr_o = idx_q;
      S_ECAP: begin
        ctl_o.out_ld   = 1'b1;
        ctl_o.out_last = emit_last;
        ctl_o.out_ovf  = dropped_q;
        raddr_o        = idx_q;
      end
      default: ;
    endcase
  end

  // Counters
  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    pass_d    = pass_q;
    k_d       = k_q;
    idx_d     = idx_q;
    unique case (state_q)
      S_LOAD: begin
        idx_d = '0;
        if (accept) begin
          count_d   = n_new;
          dropped_d = dropped_q | ~room;
          pass_d    = n_new;
        end
      end
      S_FIRST: k_d = '0;
      S_SWEEP: begin
        if (more) begin
          k_d = k_q + AW'(1);
        end
      end
      S_FLUSH: begin
        pass_d = pass_q - CW'(1);
        idx_d  = '0;
      end
      S_ECAP: begin
        if (emit_last) begin
          count_d   = '0;
          dropped_d = 1'b0;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      count_q   <= '0;
      dropped_q <= 1'b0;
      pass_q    <= '0;
      k_q       <= '0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      pass_q    <= pass_d;
      k_q       <= k_d;
      idx_q     <= idx_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ITEMS))
    else $error("element count above capacity");

  a_sweep_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |-> ((CW'(k_q) + CW'(1)) < pass_q))
    else $error("sweep index outside the current pass");

  a_pass_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH) |=> (pass_q == $past(pass_q) - CW'(1)))
    else $error("pass length did not shrink after flush");

  a_set_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_LOAD) |-> (count_q != '0))
    else $error("sorting or emitting an empty set");

  a_capture_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ECAP) |-> $past(out_free_i))
    else $error("result captured while output register busy");

endmodule

// File: rtl/core/bubble_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// bubble_sort_engine_unit
// Loads signed 32-bit values until a beat marked last, sorts them ascending
// with bubble passes, and streams the sorted set out.
// ----------------------------------------------------------------------------
// Values are loaded one beat per cycle into a RAM of MAX_ITEMS entries; beats
// past capacity are dropped and flag overflow on every result of that set.
// The beat marked last starts the sort: a pass over m elements carries the
// running maximum through the single compare unit and the one RAM read port,
// for passes m = n down to 2. Each result is then a RAM read followed by an
// output register load, and the read waits while the output register is
// stalled. Input is stalled from the last beat of a set until the final
// result is in the output register; the next set may load while that
// result still waits.
module bubble_sort_engine_unit #(
  parameter int MAX_ITEMS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bse_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bse_pkg::out_t out_data_o
);
  import bse_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);

  ctrl_t                     ctl;
  logic [AW-1:0]             waddr;
  logic [AW-1:0]             raddr;
  logic signed [VALUE_W-1:0] rdata;
  logic signed [VALUE_W-1:0] wdata;
  logic signed [VALUE_W-1:0] low;
  logic signed [VALUE_W-1:0] high;
  logic signed [VALUE_W-1:0] carry_q, carry_d;
  out_t                      out_q, out_d;
  logic                      out_valid_q, out_valid_d;
  logic                      out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  bse_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .ctl_o      (ctl),
    .waddr_o    (waddr),
    .raddr_o    (raddr)
  );

  bse_cmp u_cmp (
    .carry_i (carry_q),
    .next_i  (rdata),
    .low_o   (low),
    .high_o  (high)
  );

  always_comb begin
    unique case (ctl.wsel)
      WR_INPUT: wdata = in_data_i.value;
      WR_LOW:   wdata = low;
      WR_CARRY: wdata = carry_q;
      default:  wdata = in_data_i.value;
    endcase
  end

  bse_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ITEMS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl.ram_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    carry_d = carry_q;
    if (ctl.carry_first) begin
      carry_d = rdata;
    end else if (ctl.carry_sweep) begin
      carry_d = high;
    end
  end

  // Drop the beat once taken, load a fresh result when the sequencer says so.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (ctl.out_ld) begin
      out_d.value_res = rdata;
      out_d.last_res  = ctl.out_last;
      out_d.overflow  = ctl.out_ovf;
      out_valid_d     = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: tb/bubble_sort_engine_unit_test.sv
// ----------------------------------------------------------------------------
// bubble_sort_engine_unit_test
// Feeds sets of signed values to the sort engine: a few hand-picked sets,
// then random sets of mixed sizes, including a full store and overflowing
// sets. Each set is sorted by a local bubble-sort model when its last beat
// is accepted, and every output beat is compared against that model.
// ----------------------------------------------------------------------------
module bubble_sort_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bse_pkg::*;

  localparam int SET_CAP    = 64;
  localparam int MAX_REPORT = 10;
  localparam int DRAIN_CYC  = 20;
  localparam int RAND_BEATS = 430;

  typedef enum int {MIX_WIDE, MIX_NARROW, MIX_EDGE} mix_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  in_t  pending_beats[$];
  out_t sorted_expect[$];

  logic signed [VALUE_W-1:0] loaded_vals[$];
  bit   set_dropped;

  int   send_gap  = 0;
  bit   send_burst = 1'b0;
  int   stall_left = 0;
  bit   recv_burst = 1'b0;

  int   beats_sent;
  int   results_seen;
  int   sets_done;
  int   overflow_sets;
  int   mismatches;

  bubble_sort_engine_unit #(
    .MAX_ITEMS(SET_CAP)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #10 clk_i = ~clk_i;

  function automatic int draw_wait(bit burst);
    return burst ? 0 : $urandom_range(0, 6);
  endfunction

  // Load one beat into the model set; on the last beat sort and queue results.
  function automatic void absorb_beat(in_t b);
    logic signed [VALUE_W-1:0] vals[$];
    logic signed [VALUE_W-1:0] t;
    out_t r;
    beats_sent++;
    if (loaded_vals.size() < SET_CAP) loaded_vals.push_back(b.value);
    else set_dropped = 1'b1;
    if (!b.last) return;
    vals = loaded_vals;
    for (int p = 0; p < vals.size(); p++)
      for (int k = 0; k + 1 + p < vals.size(); k++)
        if (vals[k] > vals[k+1]) begin
          t         = vals[k];
          vals[k]   = vals[k+1];
          vals[k+1] = t;
        end
    for (int k = 0; k < vals.size(); k++) begin
      r.value_res = vals[k];
      r.last_res  = (k == vals.size() - 1);
      r.overflow  = set_dropped;
      sorted_expect.push_back(r);
    end
    sets_done++;
    if (set_dropped) overflow_sets++;
    loaded_vals.delete();
    set_dropped = 1'b0;
  endfunction

  function automatic void check_result(out_t got);
    out_t want;
    results_seen++;
    if (sorted_expect.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORT)
        $display("unexpected result: value=%0d last=%0b ovf=%0b",
                 got.value_res, got.last_res, got.overflow);
      return;
    end
    want = sorted_expect.pop_front();
    if (got.value_res !== want.value_res || got.last_res !== want.last_res ||
        got.overflow !== want.overflow) begin
      mismatches++;
      if (mismatches <= MAX_REPORT)
        $display("mismatch: exp value=%0d last=%0b ovf=%0b, got value=%0d last=%0b ovf=%0b",
                 want.value_res, want.last_res, want.overflow,
                 got.value_res, got.last_res, got.overflow);
    end
  endfunction

  // Sender: hold a stalled beat, otherwise advance after the drawn gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) absorb_beat(in_data);
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          in_data  <= pending_beats.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_burst <= ~send_burst;
          send_gap <= draw_wait(send_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check accepted beats, then stall for a drawn number of cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      check_result(out_data);
      if ($urandom_range(0, 39) == 0) recv_burst <= ~recv_burst;
      stall_left <= draw_wait(recv_burst);
      out_stall  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic signed [VALUE_W-1:0] pick_value(mix_e mix);
    case (mix)
      MIX_NARROW: return $signed($urandom_range(0, 15)) - 8;
      MIX_EDGE: begin
        case ($urandom_range(0, 4))
          0: return {1'b1, {(VALUE_W-1){1'b0}}};
          1: return {1'b0, {(VALUE_W-1){1'b1}}};
          2: return '0;
          3: return '1;
          default: return 1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_beat(logic signed [VALUE_W-1:0] v, logic last);
    in_t b;
    b.value = v;
    b.last  = last;
    pending_beats.push_back(b);
  endfunction

  function automatic void queue_set(int len, mix_e mix);
    for (int i = 0; i < len; i++) queue_beat(pick_value(mix), i == len - 1);
  endfunction

  task automatic wait_all_done();
    while (pending_beats.size() != 0 || in_valid || sorted_expect.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    logic signed [VALUE_W-1:0] smin;
    logic signed [VALUE_W-1:0] smax;
    int queued;
    int set_idx;
    int len;
    smin = {1'b1, {(VALUE_W-1){1'b0}}};
    smax = {1'b0, {(VALUE_W-1){1'b1}}};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single-element sets at both extremes
    queue_beat(smin, 1'b1);
    queue_beat(smax, 1'b1);
    // extremes mixed with duplicates
    queue_beat(smax, 1'b0);
    queue_beat(smin, 1'b0);
    queue_beat(0, 1'b0);
    queue_beat(-1, 1'b0);
    queue_beat(1, 1'b0);
    queue_beat(smin, 1'b0);
    queue_beat(smax, 1'b1);
    // two elements already ordered, then reversed
    queue_beat(-5, 1'b0);
    queue_beat(7, 1'b1);
    queue_beat(7, 1'b0);
    queue_beat(-5, 1'b1);
    // all equal
    repeat (2) queue_beat(42, 1'b0);
    queue_beat(42, 1'b1);
    // strictly descending
    for (int i = 5; i >= 0; i--) queue_beat(i, i == 0);

    // let the engine drain fully before the random part
    wait_all_done();

    queued  = 0;
    set_idx = 0;
    while (queued < RAND_BEATS) begin
      case (set_idx)
        4:       len = SET_CAP;
        9:       len = SET_CAP + 1;
        14:      len = SET_CAP + $urandom_range(2, 6);
        default: len = $urandom_range(1, 12);
      endcase
      queue_set(len, mix_e'($urandom_range(0, 2)));
      queued += len;
      set_idx++;
    end

    wait_all_done();
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("covered %0d beats in %0d sets (%0d with overflow), %0d results checked",
             beats_sent, sets_done, overflow_sets, results_seen);
    if (mismatches == 0 && sorted_expect.size() == 0) begin
      $display("bubble_sort_engine_unit_test OK");
    end else begin
      $display("%0d mismatches, %0d results still expected",
               mismatches, sorted_expect.size());
      $display("bubble_sort_engine_unit_test NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results still expected", sorted_expect.size());
    $display("bubble_sort_engine_unit_test NOT OK");
    $finish;
  end

endmodule

// File: files.f
rtl/core/bse_pkg.sv
rtl/core/bse_ram.sv
rtl/core/bse_cmp.sv
rtl/core/bse_ctrl.sv
rtl/core/bubble_sort_engine_unit.sv
tb/bubble_sort_engine_unit_test.sv
